>>> rtl/inverse_congruential_generator_defines.svh
// assertion macros used by the checker file of the generator
// no dependencies
`ifndef INVERSE_CONGRUENTIAL_GENERATOR_DEFINES_SVH
`define INVERSE_CONGRUENTIAL_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ICG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("icg assertion failed");

// next-cycle implication, disabled while in reset
`define ICG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icg assertion failed");

`endif

>>> rtl/icg_pkg.sv
// types and constants of the inverse congruential generator
// used by icg_engine and inverse_congruential_generator
package icg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd3;

	localparam logic [CFG_DATA_W-1:0] MODULUS_RST    = 32'h7FFF_FFFF;
	localparam logic [CFG_DATA_W-1:0] MULTIPLIER_RST = 32'd1;
	localparam logic [CFG_DATA_W-1:0] INCREMENT_RST  = 32'd1;
	localparam logic [CFG_DATA_W-1:0] SEED_RST       = 32'd0;

	typedef enum logic {
		OP_SEED,
		OP_STEP
	} op_t;

	typedef enum logic [1:0] {
		RED_X,
		RED_A,
		RED_C
	} red_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_ADDC,
		ST_CHK,
		ST_ALIGN,
		ST_SUB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} eng_req_t;

	typedef struct packed {
		logic done;
		logic inv_ok;
	} eng_rsp_t;

endpackage

>>> rtl/icg_engine.sv
// iterative modular arithmetic engine: shift-subtract reduction, shift-add
// modular multiply and extended euclid inversion under one sequencer
// depends on icg_pkg
module icg_engine #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  icg_pkg::eng_req_t   req,
	output icg_pkg::eng_rsp_t   rsp,
	input  logic [WIDTH-1:0]    m,
	input  logic [WIDTH-1:0]    a,
	input  logic [WIDTH-1:0]    c,
	input  logic [WIDTH-1:0]    seed,
	input  logic [WIDTH-1:0]    cur,
	output logic [WIDTH-1:0]    result
);

	localparam int SW = WIDTH + 2;
	localparam int CNTW = $clog2(WIDTH);
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(WIDTH - 1);

	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] mm);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, mm}) begin
			s = s - {1'b0, mm};
		end
		return s[WIDTH-1:0];
	endfunction

	icg_pkg::state_t st_q, st_d;
	icg_pkg::op_t    op_q;
	icg_pkg::red_t   red_q;

	logic [CNTW-1:0]      cnt_q;
	logic [CNTW-1:0]      k_q;
	logic [WIDTH-1:0]     rem_q, shf_q;
	logic [WIDTH-1:0]     xr_q, ar_q, cr_q;
	logic [WIDTH-1:0]     acc_q, mx_q, my_q;
	logic [WIDTH-1:0]     ra_q, rb_q, d_q;
	logic signed [SW-1:0] sa_q, sb_q, ds_q;
	logic [WIDTH-1:0]     res_q;
	logic                 ok_q;

	logic [WIDTH:0]       r2, red_sub;
	logic                 red_ge;
	logic [WIDTH-1:0]     red_nx;
	logic [WIDTH-1:0]     mul_add, mul_dbl, t_val;
	logic                 sub_ge, align_ok, last;
	logic [WIDTH-1:0]     ra_sub;
	logic signed [SW-1:0] sa_sub, inv_fix;

	// restoring reduction step
	assign r2      = {rem_q, shf_q[WIDTH-1]};
	assign red_sub = r2 - {1'b0, m};
	assign red_ge  = r2 >= {1'b0, m};
	assign red_nx  = red_ge ? red_sub[WIDTH-1:0] : r2[WIDTH-1:0];

	assign mul_add = add_mod(acc_q, mx_q, m);
	assign mul_dbl = add_mod(mx_q, mx_q, m);
	assign t_val   = add_mod(acc_q, cr_q, m);

	// euclid division step on aligned divisor
	assign sub_ge   = ra_q >= d_q;
	assign ra_sub   = sub_ge ? (ra_q - d_q) : ra_q;
	assign sa_sub   = sub_ge ? (sa_q - ds_q) : sa_q;
	assign align_ok = {d_q, 1'b0} <= {1'b0, ra_q};
	assign inv_fix  = sa_q[SW-1] ? (sa_q + $signed(SW'(m))) : sa_q;

	assign last = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= icg_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			icg_pkg::ST_IDLE: begin
				if (req.start) begin
					st_d = icg_pkg::ST_RED;
				end
			end
			icg_pkg::ST_RED: begin
				if (last) begin
					if (red_q == icg_pkg::RED_C) begin
						st_d = icg_pkg::ST_MUL;
					end else if (red_q == icg_pkg::RED_X && op_q == icg_pkg::OP_SEED) begin
						st_d = icg_pkg::ST_DONE;
					end
				end
			end
			icg_pkg::ST_MUL: begin
				if (last) begin
					st_d = icg_pkg::ST_ADDC;
				end
			end
			icg_pkg::ST_ADDC: st_d = icg_pkg::ST_CHK;
			icg_pkg::ST_CHK: begin
				st_d = (rb_q == '0) ? icg_pkg::ST_DONE : icg_pkg::ST_ALIGN;
			end
			icg_pkg::ST_ALIGN: begin
				if (!align_ok) begin
					st_d = icg_pkg::ST_SUB;
				end
			end
			icg_pkg::ST_SUB: begin
				if (k_q == '0) begin
					st_d = icg_pkg::ST_CHK;
				end
			end
			icg_pkg::ST_DONE: st_d = icg_pkg::ST_IDLE;
			default: st_d = icg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			icg_pkg::ST_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					red_q <= icg_pkg::RED_X;
					rem_q <= '0;
					shf_q <= (req.op == icg_pkg::OP_SEED) ? seed : cur;
					cnt_q <= CNT_MAX;
				end
			end
			icg_pkg::ST_RED: begin
				if (last) begin
					rem_q <= '0;
					cnt_q <= CNT_MAX;
					unique case (red_q)
						icg_pkg::RED_X: begin
							xr_q  <= red_nx;
							res_q <= red_nx;
							ok_q  <= 1'b1;
							shf_q <= a;
							red_q <= icg_pkg::RED_A;
						end
						icg_pkg::RED_A: begin
							ar_q  <= red_nx;
							shf_q <= c;
							red_q <= icg_pkg::RED_C;
						end
						icg_pkg::RED_C: begin
							cr_q  <= red_nx;
							acc_q <= '0;
							mx_q  <= ar_q;
							my_q  <= xr_q;
						end
						default: red_q <= icg_pkg::RED_X;
					endcase
				end else begin
					rem_q <= red_nx;
					shf_q <= shf_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			icg_pkg::ST_MUL: begin
				if (my_q[0]) begin
					acc_q <= mul_add;
				end
				mx_q  <= mul_dbl;
				my_q  <= my_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			icg_pkg::ST_ADDC: begin
				rb_q <= t_val;
				ra_q <= m;
				sa_q <= '0;
				sb_q <= SW'(1);
			end
			icg_pkg::ST_CHK: begin
				if (rb_q == '0) begin
					ok_q  <= (ra_q == WIDTH'(1));
					res_q <= inv_fix[WIDTH-1:0];
				end else begin
					d_q  <= rb_q;
					ds_q <= sb_q;
					k_q  <= '0;
				end
			end
			icg_pkg::ST_ALIGN: begin
				if (align_ok) begin
					d_q  <= d_q << 1;
					ds_q <= ds_q <<< 1;
					k_q  <= k_q + 1'b1;
				end
			end
			icg_pkg::ST_SUB: begin
				if (k_q == '0) begin
					ra_q <= rb_q;
					rb_q <= ra_sub;
					sa_q <= sb_q;
					sb_q <= sa_sub;
				end else begin
					ra_q <= ra_sub;
					sa_q <= sa_sub;
					d_q  <= d_q >> 1;
					ds_q <= ds_q >>> 1;
					k_q  <= k_q - 1'b1;
				end
			end
			icg_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = (st_q == icg_pkg::ST_DONE);
	assign rsp.inv_ok = ok_q;
	assign result     = res_q;

endmodule

>>> rtl/inverse_congruential_generator.sv
// Inverse congruential generator, top level: configuration registers, generator
// state, handshakes and the result register. Depends on icg_pkg and icg_engine.
// Each advance transaction computes x' = inverse of (a*x + c) mod m and returns it
// with the step count; no_inverse or period_found mark a halt, after which an
// advance repeats the final result. A restart transaction loads seed mod m; its
// result comes from a reduction on the engine, or is zero in the cycle after acceptance
// if the modulus is zero. An advance runs three reductions (x, a and c), a shift-add
// multiply, the addition of c and the extended euclid loop, all on the one engine. A
// halted advance, or one with modulus below two, returns its result in the cycle after
// acceptance without the engine. in_ready stays low while the engine works or a result
// waits to be taken.
module inverse_congruential_generator #(
	parameter int WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [icg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [icg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      value,
	output logic [31:0]                      step_count,
	output logic                             no_inverse,
	output logic                             period_found
);

	localparam int CW = (WIDTH < 32) ? WIDTH : 32;

	logic [icg_pkg::CFG_DATA_W-1:0] modulus_q, multiplier_q, increment_q, seed_q;
	logic [WIDTH-1:0] m_w, a_w, c_w, s_w;
	logic [WIDTH-1:0] cur_q, start_q, eng_res;
	logic [31:0]      steps_q;
	logic             halted_q, hni_q, busy_q, out_valid_q;
	icg_pkg::op_t     op_q;
	icg_pkg::eng_req_t req;
	icg_pkg::eng_rsp_t rsp;
	logic             acc, m_zero, m_lt2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= icg_pkg::MODULUS_RST;
			multiplier_q <= icg_pkg::MULTIPLIER_RST;
			increment_q  <= icg_pkg::INCREMENT_RST;
			seed_q       <= icg_pkg::SEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icg_pkg::REG_MODULUS:    modulus_q    <= cfg_data;
				icg_pkg::REG_MULTIPLIER: multiplier_q <= cfg_data;
				icg_pkg::REG_INCREMENT:  increment_q  <= cfg_data;
				icg_pkg::REG_SEED:       seed_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign m_w = WIDTH'(modulus_q[CW-1:0]);
	assign a_w = WIDTH'(multiplier_q[CW-1:0]);
	assign c_w = WIDTH'(increment_q[CW-1:0]);
	assign s_w = WIDTH'(seed_q[CW-1:0]);

	assign m_zero   = (m_w == '0);
	assign m_lt2    = (m_w < WIDTH'(2));
	assign in_ready = !busy_q && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;

	// engine starts on a restart with nonzero modulus or an advance that is not halted and has modulus of at least two
	always_comb begin
		req.start = 1'b0;
		req.op    = restart ? icg_pkg::OP_SEED : icg_pkg::OP_STEP;
		if (acc) begin
			if (restart) begin
				req.start = !m_zero;
			end else begin
				req.start = !halted_q && !m_lt2;
			end
		end
	end

	icg_engine #(
		.WIDTH(WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.m      (m_w),
		.a      (a_w),
		.c      (c_w),
		.seed   (s_w),
		.cur    (cur_q),
		.result (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			start_q     <= '0;
			steps_q     <= '0;
			halted_q    <= 1'b0;
			hni_q       <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= icg_pkg::OP_SEED;
		end else begin
			if (rsp.done) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				if (op_q == icg_pkg::OP_SEED) begin
					cur_q    <= eng_res;
					start_q  <= eng_res;
					steps_q  <= '0;
					halted_q <= 1'b0;
					hni_q    <= 1'b0;
				end else if (rsp.inv_ok) begin
					cur_q    <= eng_res;
					halted_q <= (eng_res == start_q);
				end else begin
					halted_q <= 1'b1;
					hni_q    <= 1'b1;
				end
			end else if (acc) begin
				op_q <= req.op;
				if (restart) begin
					if (m_zero) begin
						cur_q       <= '0;
						start_q     <= '0;
						steps_q     <= '0;
						halted_q    <= 1'b0;
						hni_q       <= 1'b0;
						out_valid_q <= 1'b1;
					end else begin
						busy_q      <= 1'b1;
						out_valid_q <= 1'b0;
					end
				end else if (halted_q) begin
					out_valid_q <= 1'b1;
				end else begin
					if (steps_q != '1) begin
						steps_q <= steps_q + 32'd1;
					end
					if (m_lt2) begin
						halted_q    <= 1'b1;
						hni_q       <= 1'b1;
						out_valid_q <= 1'b1;
					end else begin
						busy_q      <= 1'b1;
						out_valid_q <= 1'b0;
					end
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = 32'(cur_q);
	assign step_count   = steps_q;
	assign no_inverse   = halted_q && hni_q;
	assign period_found = halted_q && !hni_q;

endmodule

>>> rtl/icg_checker.sv
// port-level checks of the inverse congruential generator, bound to the top level
// depends on inverse_congruential_generator_defines.svh
`include "inverse_congruential_generator_defines.svh"

module icg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [31:0] step_count,
	input logic        no_inverse,
	input logic        period_found
);

	// a halt never carries both reasons
	`ICG_ASSERT_IMP(a_flags_excl, clk, arst_n, out_valid, !(no_inverse && period_found))

	// a halt always follows at least one step
	`ICG_ASSERT_IMP(a_halt_steps, clk, arst_n, out_valid && (no_inverse || period_found), step_count != 32'd0)

	// no new transaction while a result is still waiting
	`ICG_ASSERT_IMP(a_no_accept_pend, clk, arst_n, out_valid && !out_ready, !in_ready)

	// pending result value and step count hold
	`ICG_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(step_count))

endmodule

bind inverse_congruential_generator icg_checker u_icg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.value        (value),
	.step_count   (step_count),
	.no_inverse   (no_inverse),
	.period_found (period_found)
);

>>> tb/inverse_congruential_generator_tb.sv
// testbench for inverse_congruential_generator: random valid/ready traffic in phases,
// config written between phases, every result checked against expected generator state
// depends on icg_pkg and the inverse_congruential_generator rtl
module inverse_congruential_generator_tb;

	localparam int HOLD_CYCLES = 1200;
	localparam int TOTAL_ITEMS = 1075;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] step_count;
		logic        no_inverse;
		logic        period_found;
	} gen_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [icg_pkg::CFG_IDX_W-1:0]  cfg_index = icg_pkg::REG_MODULUS;
	logic [icg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           restart = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [31:0]                    value;
	logic [31:0]                    step_count;
	logic                           no_inverse;
	logic                           period_found;

	// expected generator: register copies and running state
	logic [31:0] reg_modulus = icg_pkg::MODULUS_RST;
	logic [31:0] reg_multiplier = icg_pkg::MULTIPLIER_RST;
	logic [31:0] reg_increment = icg_pkg::INCREMENT_RST;
	logic [31:0] reg_seed = icg_pkg::SEED_RST;
	logic [31:0] gen_value = '0;
	logic [31:0] gen_start = '0;
	logic [31:0] gen_steps = '0;
	logic        gen_halted = 1'b0;
	logic        gen_halt_no_inv = 1'b0;

	logic        pending_restarts [$];
	gen_result_t expected_results [$];
	gen_result_t oldest;
	int          send_max = 8;
	int          recv_max = 8;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          hold_left = 0;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          failures = 0;
	int          items_queued = 0;
	logic [31:0] prime_moduli [8] = '{32'd3, 32'd7, 32'd13, 32'd31, 32'd257, 32'd65521,
		32'd2147483647, 32'd4294967291};

	inverse_congruential_generator dut (.*);

	always #4 clk = ~clk;

	function automatic bit mod_inverse(input logic [63:0] t, input logic [63:0] m,
		output logic [63:0] inv);
		logic [63:0] r0, r1, q, r2;
		longint      s0, s1, s2;
		r0 = m;
		r1 = t;
		s0 = 0;
		s1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			r2 = r0 - q * r1;
			s2 = s0 - longint'(q) * s1;
			r0 = r1;
			r1 = r2;
			s0 = s1;
			s1 = s2;
		end
		if (r0 != 1)
			return 1'b0;
		if (s0 < 0)
			s0 = s0 + longint'(m);
		inv = s0;
		return 1'b1;
	endfunction

	function automatic gen_result_t predict_icg_step(input logic rst);
		gen_result_t res;
		logic [63:0] m, x, t, inv;
		m = {32'd0, reg_modulus};
		if (rst) begin
			gen_value = (m != 0) ? 32'({32'd0, reg_seed} % m) : 32'd0;
			gen_start = gen_value;
			gen_steps = '0;
			gen_halted = 1'b0;
			gen_halt_no_inv = 1'b0;
		end else if (!gen_halted) begin
			if (gen_steps != 32'hFFFF_FFFF)
				gen_steps++;
			if (m < 2) begin
				gen_halted = 1'b1;
				gen_halt_no_inv = 1'b1;
			end else begin
				x = {32'd0, gen_value} % m;
				t = (({32'd0, reg_multiplier} % m) * x) % m;
				t = (t + {32'd0, reg_increment} % m) % m;
				if (!mod_inverse(t, m, inv)) begin
					gen_halted = 1'b1;
					gen_halt_no_inv = 1'b1;
				end else begin
					gen_value = inv[31:0];
					if (gen_value == gen_start)
						gen_halted = 1'b1;
				end
			end
		end
		res.value = gen_value;
		res.step_count = gen_steps;
		res.no_inverse = gen_halted && gen_halt_no_inv;
		res.period_found = gen_halted && !gen_halt_no_inv;
		return res;
	endfunction

	// input side: one transaction per pending item, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_icg_step(restart));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_restarts.size() > 0) begin
					in_valid <= 1'b1;
					restart <= pending_restarts.pop_front();
					send_gap = $urandom_range(0, send_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each result transaction, stall at random or for a long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: value %0h", value);
					failures++;
				end else begin
					oldest = expected_results.pop_front();
					if (value !== oldest.value) begin
						$error("value: expected %0h, got %0h", oldest.value, value);
						failures++;
					end
					if (step_count !== oldest.step_count) begin
						$error("step_count: expected %0d, got %0d", oldest.step_count,
							step_count);
						failures++;
					end
					if (no_inverse !== oldest.no_inverse) begin
						$error("no_inverse: expected %0b, got %0b", oldest.no_inverse,
							no_inverse);
						failures++;
					end
					if (period_found !== oldest.period_found) begin
						$error("period_found: expected %0b, got %0b", oldest.period_found,
							period_found);
						failures++;
					end
				end
				recv_gap = $urandom_range(0, recv_max);
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [icg_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			icg_pkg::REG_MODULUS:    reg_modulus = data;
			icg_pkg::REG_MULTIPLIER: reg_multiplier = data;
			icg_pkg::REG_INCREMENT:  reg_increment = data;
			default:                 reg_seed = data;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [31:0] m, input logic [31:0] a,
		input logic [31:0] c, input logic [31:0] s);
		write_reg(icg_pkg::REG_MODULUS, m);
		write_reg(icg_pkg::REG_MULTIPLIER, a);
		write_reg(icg_pkg::REG_INCREMENT, c);
		write_reg(icg_pkg::REG_SEED, s);
	endtask

	task automatic queue_items(input logic with_restart, input int advances);
		@(negedge clk);
		if (with_restart)
			pending_restarts.push_back(1'b1);
		repeat (advances)
			pending_restarts.push_back(1'b0);
		items_queued += advances + int'(with_restart);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_restarts.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [31:0] m, a, c, s;
		int phase;
		phase = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// advances straight out of reset, then a restart
		queue_items(1'b0, 3);
		queue_items(1'b1, 0);
		wait_idle();
		// inverse of 2 mod 7 is 4 and back: period two, then halted repeat
		load_config(32'd7, 32'd1, 32'd0, 32'd2);
		queue_items(1'b1, 3);
		wait_idle();
		// gcd(2, 8) is not one
		load_config(32'd8, 32'd1, 32'd0, 32'd2);
		queue_items(1'b1, 2);
		wait_idle();
		// modulus zero and one
		load_config(32'd0, 32'd3, 32'hFFFF_FFFF, 32'h1234_5678);
		queue_items(1'b1, 1);
		wait_idle();
		write_reg(icg_pkg::REG_MODULUS, 32'd1);
		queue_items(1'b1, 1);
		wait_idle();
		load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_items(1'b1, 2);
		wait_idle();
		// current value left above a smaller modulus
		write_reg(icg_pkg::REG_MODULUS, 32'd1000);
		queue_items(1'b0, 2);
		wait_idle();
		load_config(32'd2, 32'd0, 32'd1, 32'd1);
		queue_items(1'b1, 1);
		wait_idle();

		while (items_queued < TOTAL_ITEMS) begin
			phase++;
			case ($urandom_range(0, 9))
				0:       m = $urandom_range(2, 64);
				1, 2:    m = prime_moduli[$urandom_range(0, 7)];
				3:       m = $urandom;
				4:       m = 32'hFFFF_FFFF;
				5:       m = $urandom_range(0, 2);
				default: m = $urandom_range(2, 4096);
			endcase
			case ($urandom_range(0, 3))
				0:       a = '0;
				1:       a = '1;
				2:       a = $urandom_range(1, 16);
				default: a = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       c = '0;
				1:       c = '1;
				2:       c = $urandom_range(1, 16);
				default: c = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       s = '0;
				1:       s = '1;
				default: s = $urandom;
			endcase
			load_config(m, a, c, s);
			send_max = $urandom_range(0, 1) ? 8 : 0;
			recv_max = $urandom_range(0, 1) ? 8 : 0;
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 9) < 8)
					queue_items(1'b1, $urandom_range(1, 24));
				else
					queue_items(1'($urandom_range(0, 1)), $urandom_range(0, 3));
			end
			if (phase == 3)
				hold_requests++;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("PASS inverse_congruential_generator");
		else
			$display("FAIL inverse_congruential_generator");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAIL inverse_congruential_generator");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/icg_pkg.sv
rtl/icg_engine.sv
rtl/inverse_congruential_generator.sv
rtl/icg_checker.sv
tb/inverse_congruential_generator_tb.sv
